### rtl/core/mdw_pkg.sv
// ----------------------------------------------------------------------------
// mdw_pkg
// Shared types and constants of the maze walker: request codes, result
// actions, cell marks and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mdw_pkg;

  // Default grid size in storage.
  localparam int MDW_MAX_ROWS_DEF = 32;
  localparam int MDW_MAX_COLS_DEF = 32;

  // Width used for grid dimension arithmetic (holds values up to 256 plus one).
  localparam int MDW_DIM_W = 10;

  // Reset value of both dimension registers.
  localparam logic [5:0] MDW_DIM_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic MDW_CFG_COLS = 1'b0;
  localparam logic MDW_CFG_ROWS = 1'b1;

  // Request function codes.
  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_STEP  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // Result actions.
  typedef enum logic [1:0] {
    ACT_ACK   = 2'd0,
    ACT_FWD   = 2'd1,
    ACT_BACK  = 2'd2,
    ACT_STUCK = 2'd3
  } action_t;

  // Cell marks.
  typedef enum logic [1:0] {
    MARK_UNTESTED  = 2'd0,
    MARK_CHECKED   = 2'd1,
    MARK_VISITED   = 2'd2,
    MARK_DISCARDED = 2'd3
  } mark_t;

  // Directions in the order they are tried.
  localparam logic [1:0] DIR_TOP  = 2'd0;
  localparam logic [1:0] DIR_LEFT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    cap_item;    // capture the accepted request
    logic    clr_start;   // rewind the mark clearing address
    logic    clr_write;   // clear one mark entry and advance
    logic    load_walls;  // store the wall bits of the request cell
    logic    place;       // place the walker on the start cell
    logic    dir_clear;   // restart the direction search at top
    logic    probe;       // read walls and mark of the neighbor
    logic    dir_next;    // advance to the next direction
    logic    fwd_push;    // push current cell and mark it visited
    logic    fwd_enter;   // move onto the neighbor and mark it checked
    logic    bk_discard;  // discard current cell and read the stack top
    logic    bk_enter;    // move onto the popped cell and mark it checked
    logic    result;      // load the result register
    action_t act;         // action reported with the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t      func;         // function code of the captured request
    logic       clr_last;     // clearing address is at the last entry
    logic       nbr_in;       // neighbor lies inside the grid in use
    logic       probe_ok;     // probed neighbor can be entered
    logic [1:0] dir;          // direction under test
    logic       stack_empty;  // move stack holds nothing
    logic       out_free;     // result register can take a result
  } status_t;

endpackage

### rtl/core/mdw_ctrl.sv
// ----------------------------------------------------------------------------
// mdw_ctrl
// Controller state machine of the maze walker. It sequences request
// capture, mark clearing, the neighbor search of a step and the writes of a
// forward move or a backtrack, and hands each result to the datapath.
// ----------------------------------------------------------------------------
module mdw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mdw_pkg::status_t sts,
  output mdw_pkg::cmd_t   cmd
);
  import mdw_pkg::*;

  typedef enum logic [3:0] {
    S_CLR_RST,
    S_IDLE,
    S_DECODE,
    S_CLR_RUN,
    S_PLACE,
    S_PROBE,
    S_CHECK,
    S_FWD_PUSH,
    S_FWD_ENTER,
    S_NOMOVE,
    S_BK_ENTER,
    S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;

  // Requests are taken only while idle.
  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    cmd       = '0;
    cmd.act   = act_r;
    case (state_r)
      S_CLR_RST: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        act_nxt = ACT_ACK;
        case (sts.func)
          FN_LOAD: begin
            cmd.load_walls = 1'b1;
            state_nxt      = S_FIN;
          end
          FN_START: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR_RUN;
          end
          FN_STEP: begin
            cmd.dir_clear = 1'b1;
            state_nxt     = S_PROBE;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_CLR_RUN: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_PROBE: begin
        if (sts.nbr_in) begin
          cmd.probe = 1'b1;
          state_nxt = S_CHECK;
        end else if (sts.dir == DIR_LEFT) begin
          state_nxt = S_NOMOVE;
        end else begin
          cmd.dir_next = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.probe_ok) begin
          state_nxt = S_FWD_PUSH;
        end else if (sts.dir == DIR_LEFT) begin
          state_nxt = S_NOMOVE;
        end else begin
          cmd.dir_next = 1'b1;
          state_nxt    = S_PROBE;
        end
      end
      S_FWD_PUSH: begin
        cmd.fwd_push = 1'b1;
        state_nxt    = S_FWD_ENTER;
      end
      S_FWD_ENTER: begin
        cmd.fwd_enter = 1'b1;
        act_nxt       = ACT_FWD;
        state_nxt     = S_FIN;
      end
      S_NOMOVE: begin
        if (sts.stack_empty) begin
          act_nxt   = ACT_STUCK;
          state_nxt = S_FIN;
        end else begin
          cmd.bk_discard = 1'b1;
          state_nxt      = S_BK_ENTER;
        end
      end
      S_BK_ENTER: begin
        cmd.bk_enter = 1'b1;
        act_nxt      = ACT_BACK;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered action.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_RST;
      act_r   <= ACT_ACK;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
    end
  end

endmodule

### rtl/core/mdw_datapath.sv
// ----------------------------------------------------------------------------
// mdw_datapath
// Datapath of the maze walker: dimension registers, wall, mark and stack
// memories, walker position, stack count, neighbor arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module mdw_datapath #(
  parameter int MAX_ROWS = mdw_pkg::MDW_MAX_ROWS_DEF,
  parameter int MAX_COLS = mdw_pkg::MDW_MAX_COLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [5:0]       cfg_data,
  input  logic [1:0]       in_func,
  input  logic [4:0]       in_row,
  input  logic [4:0]       in_col,
  input  logic [3:0]       in_wall_bits,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [4:0]       out_pos_row,
  output logic [4:0]       out_pos_col,
  output logic [1:0]       out_action,
  output logic [1:0]       out_move_dir,
  output logic [10:0]      out_depth,
  input  mdw_pkg::cmd_t    cmd,
  output mdw_pkg::status_t sts
);
  import mdw_pkg::*;

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS);
  localparam int AW   = RW + CW;
  localparam int NUM  = MAX_ROWS * MAX_COLS;
  localparam int SIW  = $clog2(NUM);
  localparam int SCW  = $clog2(NUM + 1);
  localparam int EW   = MDW_DIM_W;

  // Dimension registers.
  logic [5:0] cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= MDW_DIM_RESET;
      rows_r <= MDW_DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == MDW_CFG_COLS) cols_r <= cfg_data;
      else rows_r <= cfg_data;
    end
  end

  // Effective dimensions: zero counts as one, large values saturate.
  logic [EW-1:0] eff_rows, eff_cols;

  always_comb begin
    if (rows_r == '0) eff_rows = EW'(1);
    else if (EW'(rows_r) > EW'(MAX_ROWS)) eff_rows = EW'(MAX_ROWS);
    else eff_rows = EW'(rows_r);
    if (cols_r == '0) eff_cols = EW'(1);
    else if (EW'(cols_r) > EW'(MAX_COLS)) eff_cols = EW'(MAX_COLS);
    else eff_cols = EW'(cols_r);
  end

  // Captured request.
  logic [1:0] func_r;
  logic [4:0] row_r, col_r;
  logic [3:0] wb_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      func_r <= in_func;
      row_r  <= in_row;
      col_r  <= in_col;
      wb_r   <= in_wall_bits;
    end
  end

  // Walker and stack state.
  logic [RW-1:0]  cur_row_r;
  logic [CW-1:0]  cur_col_r;
  logic [SCW-1:0] count_r;
  logic [1:0]     dir_r;
  logic [AW-1:0]  clr_addr_r;

  // Neighbor in the direction under test.
  logic [EW-1:0] nbr_row, nbr_col;
  logic          nbr_edge;
  logic [AW-1:0] nbr_addr, cur_addr;

  always_comb begin
    nbr_row  = EW'(cur_row_r);
    nbr_col  = EW'(cur_col_r);
    nbr_edge = 1'b0;
    case (dir_r)
      2'd0: begin
        nbr_edge = (cur_row_r == '0);
        nbr_row  = EW'(cur_row_r) - EW'(1);
      end
      2'd1: nbr_col = EW'(cur_col_r) + EW'(1);
      2'd2: nbr_row = EW'(cur_row_r) + EW'(1);
      default: begin
        nbr_edge = (cur_col_r == '0);
        nbr_col  = EW'(cur_col_r) - EW'(1);
      end
    endcase
  end

  assign nbr_addr = {nbr_row[RW-1:0], nbr_col[CW-1:0]};
  assign cur_addr = {cur_row_r, cur_col_r};

  // Start cell, saturated into the grid in use.
  logic [EW-1:0] start_row, start_col;

  always_comb begin
    start_row = (EW'(row_r) >= eff_rows) ? eff_rows - EW'(1) : EW'(row_r);
    start_col = (EW'(col_r) >= eff_cols) ? eff_cols - EW'(1) : EW'(col_r);
  end

  // Load target must lie inside storage.
  logic load_ok;
  assign load_ok = (EW'(row_r) < EW'(MAX_ROWS)) && (EW'(col_r) < EW'(MAX_COLS));

  // Memories.
  logic [3:0]     walls_mem [2**AW];
  logic [1:0]     marks_mem [2**AW];
  logic [AW-1:0]  stack_mem [NUM];
  logic [3:0]     walls_q;
  logic [1:0]     marks_q;
  logic [AW-1:0]  stack_q;

  // Stack indexes for push and pop.
  logic [SCW-1:0] pop_idx;
  logic           stack_full;
  assign pop_idx    = count_r - SCW'(1);
  assign stack_full = (count_r == SCW'(NUM));

  // One mark write per cycle, selected by command.
  logic          mark_we;
  logic [AW-1:0] mark_addr;
  mark_t         mark_wd;

  always_comb begin
    mark_we   = 1'b1;
    mark_addr = cur_addr;
    mark_wd   = MARK_CHECKED;
    if (cmd.clr_write) begin
      mark_addr = clr_addr_r;
      mark_wd   = MARK_UNTESTED;
    end else if (cmd.place) begin
      mark_addr = {start_row[RW-1:0], start_col[CW-1:0]};
    end else if (cmd.fwd_push) begin
      mark_wd = MARK_VISITED;
    end else if (cmd.fwd_enter) begin
      mark_addr = nbr_addr;
    end else if (cmd.bk_discard) begin
      mark_wd = MARK_DISCARDED;
    end else if (cmd.bk_enter) begin
      mark_addr = stack_q;
    end else begin
      mark_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) marks_mem[mark_addr] <= mark_wd;
    if (cmd.load_walls && load_ok)
      walls_mem[{row_r[RW-1:0], col_r[CW-1:0]}] <= wb_r;
    if (cmd.fwd_push && !stack_full) stack_mem[count_r[SIW-1:0]] <= cur_addr;
    if (cmd.probe) begin
      walls_q <= walls_mem[nbr_addr];
      marks_q <= marks_mem[nbr_addr];
    end
    if (cmd.bk_discard) stack_q <= stack_mem[pop_idx[SIW-1:0]];
  end

  // Walker position, stack count, direction and clearing address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      count_r    <= '0;
      dir_r      <= DIR_TOP;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr_start) clr_addr_r <= '0;
      else if (cmd.clr_write) clr_addr_r <= clr_addr_r + AW'(1);
      if (cmd.dir_clear) dir_r <= DIR_TOP;
      else if (cmd.dir_next) dir_r <= dir_r + 2'd1;
      if (cmd.place) begin
        cur_row_r <= start_row[RW-1:0];
        cur_col_r <= start_col[CW-1:0];
        count_r   <= '0;
      end
      if (cmd.fwd_push && !stack_full) count_r <= count_r + SCW'(1);
      if (cmd.fwd_enter) begin
        cur_row_r <= nbr_row[RW-1:0];
        cur_col_r <= nbr_col[CW-1:0];
      end
      if (cmd.bk_discard) count_r <= pop_idx;
      if (cmd.bk_enter) {cur_row_r, cur_col_r} <= stack_q;
    end
  end

  // Result register.
  logic        out_valid_r;
  logic [4:0]  res_row_r, res_col_r;
  logic [1:0]  res_act_r, res_dir_r;
  logic [10:0] res_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      res_row_r   <= 5'(cur_row_r);
      res_col_r   <= 5'(cur_col_r);
      res_act_r   <= cmd.act;
      res_dir_r   <= (cmd.act == ACT_FWD) ? dir_r : DIR_TOP;
      res_depth_r <= 11'(count_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pos_row  = res_row_r;
  assign out_pos_col  = res_col_r;
  assign out_action   = res_act_r;
  assign out_move_dir = res_dir_r;
  assign out_depth    = res_depth_r;

  // Status toward the controller.
  always_comb begin
    sts.func        = func_t'(func_r);
    sts.clr_last    = &clr_addr_r;
    sts.nbr_in      = !nbr_edge && (nbr_row < eff_rows) && (nbr_col < eff_cols);
    sts.probe_ok    = !walls_q[2'(dir_r + 2'd2)] && (marks_q == MARK_UNTESTED);
    sts.dir         = dir_r;
    sts.stack_empty = (count_r == '0);
    sts.out_free    = !out_valid_r || !out_stall;
  end

endmodule

### rtl/core/maze_dfs_step_walker_unit.sv
// ----------------------------------------------------------------------------
// maze_dfs_step_walker_unit
// Depth-first maze walker. Requests load cell walls, start a walk on a cell,
// take one search step or only acknowledge; each request gives one result.
//
//   Channel  Ports                                  Handshake
//   in       in_func in_row in_col in_wall_bits     in_valid / in_stall
//   out      out_pos_row out_pos_col out_action     out_valid / out_stall
//            out_move_dir out_depth
//   cfg      cfg_index cfg_data                     cfg_we
//
// A load passes through decode to the result state. A step probes each
// neighbor inside the grid through the single mark and wall read port and
// checks it, skips each neighbor outside it, and then makes the move writes.
// A start clears every mark entry, one per cycle, and then places the walker.
// The same clearing pass runs after reset, with in_stall high.
// A finished result waits in the output register while the next request is
// accepted; a held out_stall stalls the request after it at its last cycle.
// ----------------------------------------------------------------------------
module maze_dfs_step_walker_unit #(
  parameter int MAX_ROWS = mdw_pkg::MDW_MAX_ROWS_DEF,
  parameter int MAX_COLS = mdw_pkg::MDW_MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_row,
  input  logic [4:0]  in_col,
  input  logic [3:0]  in_wall_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_pos_row,
  output logic [4:0]  out_pos_col,
  output logic [1:0]  out_action,
  output logic [1:0]  out_move_dir,
  output logic [10:0] out_depth
);
  import mdw_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Controller.
  mdw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  mdw_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_func      (in_func),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_wall_bits (in_wall_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pos_row  (out_pos_row),
    .out_pos_col  (out_pos_col),
    .out_action   (out_action),
    .out_move_dir (out_move_dir),
    .out_depth    (out_depth),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
